@@ design/fpms_pkg.sv @@
// fpms_pkg: opcodes and shared types for the fixed-priority multi-cpu scheduler
// no dependencies; imported by fpms_best_unit, fixed_priority_multicpu_scheduler and its testbench
package fpms_pkg;

	// request opcodes
	localparam logic [2:0] OP_LOAD    = 3'd0;
	localparam logic [2:0] OP_UNBLOCK = 3'd1;
	localparam logic [2:0] OP_TICK    = 3'd2;
	localparam logic [2:0] OP_BLOCK   = 3'd3;
	localparam logic [2:0] OP_EXIT    = 3'd4;

	// control from the sequencer to the shared compare unit
	typedef struct packed {
		logic clear;   // start of a new pick, forget the best so far
		logic take;    // a candidate is presented this cycle
	} cmp_ctrl_t;

endpackage

@@ design/fpms_best_unit.sv @@
// fpms_best_unit: shared period compare unit, keeps the best candidate of a pick
// depends on fpms_pkg (cmp_ctrl_t)
module fpms_best_unit import fpms_pkg::*; #(
	parameter int IDX_W       = 5,
	parameter int PERIOD_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmp_ctrl_t              ctrl,
	input  logic [IDX_W-1:0]       cand_index,
	input  logic [PERIOD_BITS-1:0] cand_period,
	output logic                   found,
	output logic [IDX_W-1:0]       best_index
);

	logic                   found_q;
	logic [IDX_W-1:0]       best_index_q;
	logic [PERIOD_BITS-1:0] best_period_q;
	logic                   better;

	// strictly smaller period wins, so earlier candidates keep ties
	assign better = ctrl.take && (!found_q || (cand_period < best_period_q));

	// found flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.clear) begin
			found_q <= 1'b0;
		end else if (better) begin
			found_q <= 1'b1;
		end
	end

	// best candidate payload
	always_ff @(posedge clk) begin
		if (better) begin
			best_index_q  <= cand_index;
			best_period_q <= cand_period;
		end
	end

	assign found      = found_q;
	assign best_index = best_index_q;

endmodule

@@ design/fixed_priority_multicpu_scheduler.sv @@
// fixed_priority_multicpu_scheduler: rate monotonic scheduler top level
// depends on fpms_pkg and fpms_best_unit
//
// Load and unblock requests are absorbed and give no result.
// A tick, block or exit request for a cpu runs a pick from acceptance to the
// result register. The current task's period is read on acceptance. The period
// memory is then walked one task per cycle through a single read port into
// one shared compare unit. The S_LAST state drains the read stage, and the
// S_WB state writes back the running bit and the cpu's current task.
// The request side stalls for that whole time, and longer while the write-back
// waits on an earlier result that is still held. A finished result waits in
// the output register, so the next request can be taken while it is pending.
// Requests with an unknown opcode, an out-of-range task or cpu are dropped.
module fixed_priority_multicpu_scheduler import fpms_pkg::*; #(
	parameter int MAX_TASKS   = 32,
	parameter int NUM_CPUS    = 4,
	parameter int PERIOD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [4:0]  task_id,
	input  logic [1:0]  cpu_index,
	input  logic [15:0] task_period,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  chosen_task,
	output logic        idle
);

	localparam int TASK_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam logic [TASK_W-1:0] LAST_IDX = TASK_W'(MAX_TASKS - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_LAST = 2'd2;
	localparam logic [1:0] S_WB   = 2'd3;

	logic [1:0]             state_q;
	logic [TASK_W-1:0]      idx_q;
	logic [CPU_W-1:0]       ev_cpu_q;
	logic [MAX_TASKS-1:0]   ready_q;
	logic [MAX_TASKS-1:0]   running_q;
	logic [NUM_CPUS-1:0]    cpu_busy_q;
	logic [TASK_W-1:0]      cpu_task_q [NUM_CPUS];
	logic [PERIOD_BITS-1:0] period_mem [MAX_TASKS];
	logic [PERIOD_BITS-1:0] rd_data_s1;
	logic                   cand_valid_s1;
	logic [TASK_W-1:0]      cand_idx_s1;
	logic                   out_valid_q;
	logic [4:0]             chosen_q;
	logic                   idle_q;

	logic              in_take;
	logic              is_event;
	logic              cpu_ok;
	logic              task_ok;
	logic              start;
	logic              mark_ready;
	logic              load_wr;
	logic [CPU_W-1:0]  cpu_sel;
	logic [TASK_W-1:0] task_sel;
	logic              cur_busy;
	logic [TASK_W-1:0] cur_task;
	logic              cur_elig;
	logic [TASK_W-1:0] rd_addr;
	logic              wb_go;
	cmp_ctrl_t         cmp_ctrl;
	logic              found;
	logic [TASK_W-1:0] best_index;

	// request decode
	assign in_stall   = (state_q != S_IDLE);
	assign in_take    = in_valid && !in_stall;
	assign is_event   = (opcode == OP_TICK) || (opcode == OP_BLOCK) || (opcode == OP_EXIT);
	assign cpu_ok     = (int'(cpu_index) < NUM_CPUS);
	assign task_ok    = (int'(task_id) < MAX_TASKS);
	assign start      = in_take && is_event && cpu_ok;
	assign mark_ready = in_take && task_ok && ((opcode == OP_LOAD) || (opcode == OP_UNBLOCK));
	assign load_wr    = mark_ready && (opcode == OP_LOAD);
	assign cpu_sel    = CPU_W'(cpu_index);
	assign task_sel   = TASK_W'(task_id);

	// current task of the addressed cpu; it stays a candidate only on a tick
	assign cur_busy = cpu_busy_q[cpu_sel];
	assign cur_task = cpu_task_q[cpu_sel];
	assign cur_elig = cur_busy && ready_q[cur_task] && (opcode == OP_TICK);

	assign rd_addr = (state_q == S_SCAN) ? idx_q : cur_task;
	assign wb_go   = (state_q == S_WB) && (!out_valid_q || !out_stall);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			ev_cpu_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q  <= S_SCAN;
						idx_q    <= '0;
						ev_cpu_q <= cpu_sel;
					end
				end
				S_SCAN: begin
					if (idx_q == LAST_IDX) begin
						state_q <= S_LAST;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_LAST: begin
					state_q <= S_WB;
				end
				S_WB: begin
					if (wb_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ready and running bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q   <= '0;
			running_q <= '0;
		end else begin
			if (mark_ready) begin
				ready_q[task_sel] <= 1'b1;
			end
			if (start && cur_busy) begin
				running_q[cur_task] <= 1'b0;
				if (opcode != OP_TICK) begin
					ready_q[cur_task] <= 1'b0;
				end
			end
			if (wb_go && found) begin
				running_q[best_index] <= 1'b1;
			end
		end
	end

	// per-cpu current task
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_busy_q <= '0;
			for (int c = 0; c < NUM_CPUS; c++) begin
				cpu_task_q[c] <= '0;
			end
		end else if (wb_go) begin
			cpu_busy_q[ev_cpu_q] <= found;
			cpu_task_q[ev_cpu_q] <= found ? best_index : '0;
		end
	end

	// period memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (load_wr) begin
			period_mem[task_sel] <= PERIOD_BITS'(32'(task_period));
		end
		rd_data_s1 <= period_mem[rd_addr];
	end

	// candidate stage, aligned with the memory read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_valid_s1 <= 1'b0;
		end else if (start) begin
			cand_valid_s1 <= cur_elig;
		end else if (state_q == S_SCAN) begin
			cand_valid_s1 <= ready_q[idx_q] && !running_q[idx_q];
		end else begin
			cand_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		cand_idx_s1 <= rd_addr;
	end

	assign cmp_ctrl.clear = start;
	assign cmp_ctrl.take  = cand_valid_s1;

	fpms_best_unit #(
		.IDX_W       (TASK_W),
		.PERIOD_BITS (PERIOD_BITS)
	) u_best (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (cmp_ctrl),
		.cand_index  (cand_idx_s1),
		.cand_period (rd_data_s1),
		.found       (found),
		.best_index  (best_index)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wb_go) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_go) begin
			chosen_q <= found ? 5'(best_index) : 5'd0;
			idle_q   <= !found;
		end
	end

	assign out_valid   = out_valid_q;
	assign chosen_task = chosen_q;
	assign idle        = idle_q;

	// a new result only appears after a write-back cycle
	a_result_after_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_WB))
		else $error("result appeared without write-back");

	// a freshly scheduled task is marked running
	a_chosen_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WB && wb_go && found) |=> running_q[$past(best_index)])
		else $error("chosen task not marked running");

	// an idle result always reports task zero
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && idle_q) |-> (chosen_q == 5'd0))
		else $error("idle result with non-zero task");

	// the compare unit only sees candidates while a pick is in progress
	a_take_in_pick: assert property (@(posedge clk) disable iff (!arst_n)
		cand_valid_s1 |-> (state_q == S_SCAN || state_q == S_LAST))
		else $error("candidate outside a pick");

endmodule

@@ dv/fixed_priority_multicpu_scheduler_tb.sv @@
// fixed_priority_multicpu_scheduler_tb: self-checking bench for the rate monotonic scheduler
// depends on fpms_pkg and the fixed_priority_multicpu_scheduler rtl; a directed table,
// then random requests, each pick checked against an in-bench scheduler or a typed table row
module fixed_priority_multicpu_scheduler_tb import fpms_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NTASKS       = 32;
	localparam int NCPUS        = 4;
	localparam int USEFUL_ITEMS = 550;
	localparam int HOLD_AT      = 200;
	localparam int DRAIN_AT     = 350;
	localparam int CALM_AT      = 470;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 60;
	localparam int WATCHDOG_NS  = 2_000_000;
	localparam int DIR_N        = 24;

	// spare opcodes, the block drops them
	localparam logic [2:0] OP_SPARE_5 = 3'd5;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [2:0]  op;
		logic [4:0]  tid;
		logic [1:0]  cpu;
		logic [15:0] per;
		logic        typed;
		logic [4:0]  t_pick;
		logic        t_idle;
	} stim_row_t;

	typedef struct packed {
		logic [4:0] pick;
		logic       goes_idle;
	} sched_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  opcode = OP_LOAD;
	logic [4:0]  task_id = '0;
	logic [1:0]  cpu_index = '0;
	logic [15:0] task_period = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [4:0]  chosen_task;
	logic        idle;

	// typed expectation travelling with the request
	logic        row_typed = 1'b0;
	logic [4:0]  row_pick = '0;
	logic        row_idle = 1'b0;

	// in-bench copy of the scheduler state
	bit          tbl_ready   [NTASKS];
	bit          tbl_running [NTASKS];
	logic [15:0] tbl_period  [NTASKS];
	bit          cpu_busy    [NCPUS];
	logic [4:0]  cpu_task    [NCPUS];

	sched_result_t expected_picks[$];
	int          mismatches = 0;
	bit          calm = 1'b0;
	bit          hold_armed = 1'b0;
	bit          hold_done = 1'b0;
	bit          ever_loaded [NTASKS];

	stim_row_t directed_rows [DIR_N] = '{
		// events straight after reset, every cpu idle
		'{OP_TICK,    5'd0,  2'd0, 16'h0000, 1'b1, 5'd0, 1'b1},
		'{OP_BLOCK,   5'd31, 2'd1, 16'hFFFF, 1'b1, 5'd0, 1'b1},
		'{OP_EXIT,    5'd0,  2'd3, 16'h0000, 1'b1, 5'd0, 1'b1},
		// spare opcodes, dropped
		'{OP_SPARE_5, 5'd3,  2'd2, 16'h1234, 1'b0, 5'd0, 1'b0},
		'{OP_SPARE_6, 5'd17, 2'd1, 16'hA5A5, 1'b0, 5'd0, 1'b0},
		'{OP_SPARE_7, 5'd31, 2'd3, 16'hFFFF, 1'b0, 5'd0, 1'b0},
		// largest period, zero period, unit period
		'{OP_LOAD,    5'd31, 2'd0, 16'hFFFF, 1'b0, 5'd0, 1'b0},
		'{OP_LOAD,    5'd0,  2'd3, 16'h0000, 1'b0, 5'd0, 1'b0},
		'{OP_LOAD,    5'd5,  2'd0, 16'h0001, 1'b0, 5'd0, 1'b0},
		'{OP_TICK,    5'd0,  2'd0, 16'h0000, 1'b0, 5'd0, 1'b0},
		'{OP_TICK,    5'd0,  2'd1, 16'h0000, 1'b0, 5'd0, 1'b0},
		'{OP_TICK,    5'd0,  2'd2, 16'h0000, 1'b0, 5'd0, 1'b0},
		// everything ready is already running elsewhere
		'{OP_TICK,    5'd0,  2'd3, 16'h0000, 1'b0, 5'd0, 1'b0},
		// tie against the current task
		'{OP_LOAD,    5'd7,  2'd0, 16'h0001, 1'b0, 5'd0, 1'b0},
		'{OP_TICK,    5'd0,  2'd1, 16'h0000, 1'b0, 5'd0, 1'b0},
		// reload of a running task
		'{OP_LOAD,    5'd5,  2'd0, 16'hFFFF, 1'b0, 5'd0, 1'b0},
		'{OP_BLOCK,   5'd0,  2'd1, 16'h0000, 1'b0, 5'd0, 1'b0},
		'{OP_UNBLOCK, 5'd5,  2'd2, 16'h0000, 1'b0, 5'd0, 1'b0},
		'{OP_EXIT,    5'd0,  2'd0, 16'h0000, 1'b0, 5'd0, 1'b0},
		// tie between two fresh tasks, lower index wins
		'{OP_LOAD,    5'd12, 2'd0, 16'h0002, 1'b0, 5'd0, 1'b0},
		'{OP_LOAD,    5'd13, 2'd0, 16'h0002, 1'b0, 5'd0, 1'b0},
		'{OP_TICK,    5'd0,  2'd3, 16'h0000, 1'b0, 5'd0, 1'b0},
		'{OP_EXIT,    5'd0,  2'd2, 16'h0000, 1'b0, 5'd0, 1'b0},
		'{OP_BLOCK,   5'd0,  2'd3, 16'h0000, 1'b0, 5'd0, 1'b0}
	};

	fixed_priority_multicpu_scheduler dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.task_id     (task_id),
		.cpu_index   (cpu_index),
		.task_period (task_period),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.chosen_task (chosen_task),
		.idle        (idle)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// apply one request to the scheduler copy; returns 1 when a pick results
	function automatic bit schedule_request(input logic [2:0] op, input logic [4:0] tid,
			input logic [1:0] cpu, input logic [15:0] per,
			output logic [4:0] pick, output logic goes_idle);
		bit         found;
		logic [4:0] best;
		logic [15:0] best_per;
		logic [4:0] cur;
		int         i;
		found = 1'b0;
		best = '0;
		best_per = '0;
		pick = '0;
		goes_idle = 1'b0;
		if (op == OP_LOAD || op == OP_UNBLOCK) begin
			tbl_ready[tid] = 1'b1;
			if (op == OP_LOAD)
				tbl_period[tid] = per;
			return 1'b0;
		end
		if (op != OP_TICK && op != OP_BLOCK && op != OP_EXIT)
			return 1'b0;
		// free the current task; block and exit also take it off the ready set
		if (cpu_busy[cpu]) begin
			cur = cpu_task[cpu];
			tbl_running[cur] = 1'b0;
			if (op != OP_TICK)
				tbl_ready[cur] = 1'b0;
			if (tbl_ready[cur]) begin
				found = 1'b1;
				best = cur;
				best_per = tbl_period[cur];
			end
		end
		// strictly smaller period replaces, so current task then lowest index win ties
		for (i = 0; i < NTASKS; i++) begin
			if (tbl_ready[i] && !tbl_running[i] && (!found || tbl_period[i] < best_per)) begin
				found = 1'b1;
				best = i[4:0];
				best_per = tbl_period[i];
			end
		end
		if (found) begin
			tbl_running[best] = 1'b1;
			cpu_busy[cpu] = 1'b1;
			cpu_task[cpu] = best;
			pick = best;
		end else begin
			cpu_busy[cpu] = 1'b0;
			cpu_task[cpu] = '0;
			goes_idle = 1'b1;
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("%0t ns: mismatch on %s, got %0d, want %0d", $time, what, got, want);
	endtask

	// offer one request, with an optional gap first, and wait until it is taken
	task automatic offer_request(input logic [2:0] op, input logic [4:0] tid,
			input logic [1:0] cpu, input logic [15:0] per,
			input logic typed, input logic [4:0] t_pick, input logic t_idle);
		if (!calm && !(hold_armed && !hold_done) && $urandom_range(4, 0) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(9, 1)) @(negedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		task_id     <= tid;
		cpu_index   <= cpu;
		task_period <= per;
		row_typed   <= typed;
		row_pick    <= t_pick;
		row_idle    <= t_idle;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// scoreboard: results first, then the request taken at the same edge
	always @(posedge clk) begin
		sched_result_t want;
		sched_result_t fresh;
		logic [4:0]    p_pick;
		logic          p_idle;
		if (arst_n) begin
			if (out_valid === 1'b1 && out_stall == 1'b0) begin
				if (expected_picks.size() == 0) begin
					report_mismatch("unexpected result, chosen_task", int'(chosen_task), -1);
				end else begin
					want = expected_picks.pop_front();
					if (chosen_task !== want.pick)
						report_mismatch("chosen_task", int'(chosen_task), int'(want.pick));
					if (idle !== want.goes_idle)
						report_mismatch("idle", int'(idle), int'(want.goes_idle));
				end
			end
			if (in_valid && in_stall === 1'b0) begin
				if (schedule_request(opcode, task_id, cpu_index, task_period,
						p_pick, p_idle)) begin
					if (row_typed) begin
						fresh.pick      = row_pick;
						fresh.goes_idle = row_idle;
					end else begin
						fresh.pick      = p_pick;
						fresh.goes_idle = p_idle;
					end
					expected_picks.insert(expected_picks.size(), fresh);
				end
			end
		end
	end

	// receiver: short random stalls, one long hold-off, none near the end
	initial begin
		int k;
		forever begin
			if (hold_armed && !hold_done) begin
				out_stall <= 1'b1;
				for (k = 0; k < HOLD_CYCLES; k++)
					@(negedge clk);
				hold_done = 1'b1;
			end else if (calm || $urandom_range(7, 0) != 0) begin
				out_stall <= 1'b0;
				@(negedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(9, 1)) @(negedge clk);
			end
		end
	end

	// sender: reset, directed table, random requests, then drain
	initial begin
		int         r;
		int         useful;
		logic [2:0] op;
		logic [4:0] tid;
		logic [1:0] cpu;
		logic [15:0] per;
		bit         any_loaded;
		useful = 0;
		any_loaded = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int n = 0; n < DIR_N; n++) begin
			if (directed_rows[n].op == OP_LOAD) begin
				ever_loaded[directed_rows[n].tid] = 1'b1;
				any_loaded = 1'b1;
			end
			offer_request(directed_rows[n].op, directed_rows[n].tid, directed_rows[n].cpu,
				directed_rows[n].per, directed_rows[n].typed, directed_rows[n].t_pick,
				directed_rows[n].t_idle);
		end

		while (useful < USEFUL_ITEMS) begin
			r = $urandom_range(99, 0);
			tid = 5'($urandom_range(NTASKS - 1, 0));
			cpu = 2'($urandom_range(NCPUS - 1, 0));
			// often tight periods so ties come up, some extremes, the rest anywhere
			case ($urandom_range(9, 0))
				0, 1, 2, 3: per = 16'($urandom_range(4, 1));
				4:          per = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
				default:    per = 16'($urandom);
			endcase
			if (r < 5) begin
				op = 3'($urandom_range(OP_SPARE_7, OP_SPARE_5));
			end else if (r < 35 || (r < 50 && !any_loaded)) begin
				op = OP_LOAD;
			end else if (r < 50) begin
				// unblock only tasks that have a period stored
				op = OP_UNBLOCK;
				while (!ever_loaded[tid])
					tid = 5'($urandom_range(NTASKS - 1, 0));
			end else if (r < 75) begin
				op = OP_TICK;
			end else if (r < 88) begin
				op = OP_BLOCK;
			end else begin
				op = OP_EXIT;
			end
			if (op == OP_LOAD) begin
				ever_loaded[tid] = 1'b1;
				any_loaded = 1'b1;
			end
			if (op != OP_SPARE_5 && op != OP_SPARE_6 && op != OP_SPARE_7) begin
				useful++;
				if (useful == HOLD_AT)
					hold_armed = 1'b1;
				if (useful == CALM_AT)
					calm = 1'b1;
				// pause until every pick has come out
				if (useful == DRAIN_AT) begin
					in_valid <= 1'b0;
					@(negedge clk);
					while (expected_picks.size() != 0)
						@(negedge clk);
				end
			end
			offer_request(op, tid, cpu, per, 1'b0, 5'd0, 1'b0);
		end

		// drain and let any stray result show up
		in_valid <= 1'b0;
		@(negedge clk);
		while (expected_picks.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog
	initial begin
		#(WATCHDOG_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ filelist.f @@
design/fpms_pkg.sv
design/fpms_best_unit.sv
design/fixed_priority_multicpu_scheduler.sv
dv/fixed_priority_multicpu_scheduler_tb.sv
